// ----- sv/fibm_pkg.sv -----
// Shared constants, types and helpers for the Fibonacci-like term core.
package fibm_pkg;

  // Exponent bits walked by the square-and-multiply loop
  localparam int INDEX_BITS = 31;
  // Width of the term_index field on the bus
  localparam int IDX_FIELD_W = 31;
  // Width of any residue (modulus at most 10000)
  localparam int MOD_W = 14;
  // Width of values fed to the bit-serial reducer
  localparam int RED_W = 32;
  // Reducer retires two bits a cycle
  localparam int RED_STEPS = RED_W / 2;
  localparam int RED_CNT_W = $clog2(RED_STEPS + 1);
  // Loop counter holds INDEX_BITS itself
  localparam int CNT_W = $clog2(INDEX_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_WAIT,
    ST_FIN,
    ST_FWAIT,
    ST_OUT
  } state_e;

  // Control shared by every bit cell of the exponent chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Ten to the digit count, saturated at four digits
  function automatic logic [MOD_W-1:0] mod_of(input logic [2:0] m);
    logic [MOD_W-1:0] r;
    case (m)
      3'd0:    r = MOD_W'(1);
      3'd1:    r = MOD_W'(10);
      3'd2:    r = MOD_W'(100);
      3'd3:    r = MOD_W'(1000);
      default: r = MOD_W'(10000);
    endcase
    return r;
  endfunction

endpackage

// ----- sv/fibm_cell.sv -----
// One bit cell of the exponent chain; hands its bit to the next cell on each step.
module fibm_cell
  import fibm_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      load_bit_i,
  input  logic      prev_bit_i,
  output logic      bit_o
);

  logic bit_q;
  logic bit_d;

  // Load from the beat, else take the neighbour's bit on a step
  always_comb begin
    bit_d = bit_q;
    if (ctl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctl_i.shift) begin
      bit_d = prev_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

// ----- sv/fibm_reduce.sv -----
// Bit-serial modular reducer: value mod modulus, two bits per cycle.
module fibm_reduce
  import fibm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RED_W-1:0] value_i,
  input  logic [MOD_W-1:0] mod_i,
  output logic             done_o,
  output logic [MOD_W-1:0] res_o
);

  logic [MOD_W-1:0]     r_q, r_d;
  logic [RED_W-1:0]     val_q;
  logic [MOD_W-1:0]     mod_q;
  logic [RED_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [MOD_W:0]       t1;
  logic [MOD_W:0]       t2;

  // Two restoring steps: shift in a bit, subtract once if over
  always_comb begin
    t1 = {r_q, val_q[RED_W-1]};
    if (t1 >= {1'b0, mod_q}) begin
      t1 = t1 - {1'b0, mod_q};
    end
    t2 = {t1[MOD_W-1:0], val_q[RED_W-2]};
    if (t2 >= {1'b0, mod_q}) begin
      t2 = t2 - {1'b0, mod_q};
    end
    r_d = t2[MOD_W-1:0];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      val_q <= value_i;
      mod_q <= mod_i;
    end else if (busy_q) begin
      r_q   <= r_d;
      val_q <= {val_q[RED_W-3:0], 2'b00};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= RED_CNT_W'(RED_STEPS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - RED_CNT_W'(1);
      if (cnt_q == RED_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

`ifndef SYNTHESIS
  a_res_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < mod_q))
    else $error("reducer result not below modulus");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q))
    else $error("reducer done without a run");
`endif

endmodule

// ----- sv/fibonacci_like_term_mod_pow10_core.sv -----
// Top level: term n of a Fibonacci-like sequence modulo ten to the digit count.
//
// One beat in gives one beat out: f(n) mod 10^m for f(0)=seed_first,
// f(1)=seed_second. A digit count above four is treated as four. Items are
// handled one at a time: the next input beat can be taken once the result
// has moved into the output register. The seed reduction comes first, then
// the exponent walks a chain of INDEX_BITS bit cells, one bit per loop pass
// (a step that starts the bit-serial modular reducers, then a wait on them),
// and a final pass of the same kind forms the term. A finished result is
// held in the output register so a new beat can be taken while it waits; a
// result still waiting there when the next one is ready stalls the block.
module fibonacci_like_term_mod_pow10_core
  import fibm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // [31:0] seed_first, [63:32] seed_second, [94:64] term_index,
  // [97:95] digit_count, [103:98] zero
  input  logic [103:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // [13:0] term_value, [15:14] zero
  output logic [15:0]  m_tdata_o
);

  state_e state_q, state_d;

  logic [MOD_W-1:0] mod_q;
  logic [MOD_W-1:0] a_q, b_q;
  logic [MOD_W-1:0] x_q, y_q;
  logic [MOD_W-1:0] x_d, y_d;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [MOD_W-1:0] out_q;

  logic             accept;
  logic             out_load;
  logic             start0, start1;
  logic [RED_W-1:0] val0, val1;
  logic [MOD_W-1:0] red_mod;
  logic             done0, done1;
  logic [MOD_W-1:0] res0, res1;
  cell_ctl_t        cell_ctl;
  logic [INDEX_BITS:0] chain;
  logic             cur_bit;

  logic [MOD_W+1:0] lin_sum;
  logic [28:0]      p1, p2;
  logic [27:0]      pf;
  logic [MOD_W:0]   add_sum;

  assign accept     = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || m_tready_i);

  // Exponent bit chain, most significant bit leaves at the top
  assign chain[0] = 1'b0;
  for (genvar i = 0; i < INDEX_BITS; i++) begin : g_cell
    logic load_bit;
    if (i < IDX_FIELD_W) begin : g_fld
      assign load_bit = s_tdata_i[64 + i];
    end else begin : g_zero
      assign load_bit = 1'b0;
    end
    fibm_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl),
      .load_bit_i (load_bit),
      .prev_bit_i (chain[i]),
      .bit_o      (chain[i+1])
    );
  end
  assign cur_bit = chain[INDEX_BITS];

  // Doubling products: F(2k)=x(x+2y), F(2k-1)=x^2+y^2
  assign lin_sum = (MOD_W+2)'(x_q) + {1'b0, y_q, 1'b0};
  assign p1      = 29'(x_q) * 29'(lin_sum);
  assign p2      = 29'(x_q) * 29'(x_q) + 29'(y_q) * 29'(y_q);
  // Final combination F(n)*b + F(n-1)*a
  assign pf      = 28'(x_q) * 28'(b_q) + 28'(y_q) * 28'(a_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) begin state_d = ST_SEED; end
      ST_SEED:  if (done0) begin state_d = ST_MUL; end
      ST_MUL:   state_d = ST_WAIT;
      ST_WAIT: begin
        if (done0) begin
          state_d = (cnt_q == CNT_W'(1)) ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN:   state_d = ST_FWAIT;
      ST_FWAIT: if (done0) begin state_d = ST_OUT; end
      ST_OUT:   if (out_load) begin state_d = ST_IDLE; end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    start0         = 1'b0;
    start1         = 1'b0;
    val0           = '0;
    val1           = '0;
    red_mod        = mod_q;
    cell_ctl.load  = 1'b0;
    cell_ctl.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        start0        = accept;
        start1        = accept;
        val0          = s_tdata_i[31:0];
        val1          = s_tdata_i[63:32];
        red_mod       = mod_of(s_tdata_i[97:95]);
        cell_ctl.load = accept;
      end
      ST_MUL: begin
        start0 = 1'b1;
        start1 = 1'b1;
        val0   = RED_W'(p1);
        val1   = RED_W'(p2);
      end
      ST_WAIT:  cell_ctl.shift = done0;
      ST_FIN: begin
        start0 = 1'b1;
        val0   = RED_W'(pf);
      end
      default: begin
      end
    endcase
  end

  // Pair update after a pass: optional step by the base matrix
  always_comb begin
    add_sum = {1'b0, res0} + {1'b0, res1};
    if (add_sum >= {1'b0, mod_q}) begin
      add_sum = add_sum - {1'b0, mod_q};
    end
    if (cur_bit) begin
      x_d = add_sum[MOD_W-1:0];
      y_d = res0;
    end else begin
      x_d = res0;
      y_d = res1;
    end
  end

  fibm_reduce u_red0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start0),
    .value_i (val0),
    .mod_i   (red_mod),
    .done_o  (done0),
    .res_o   (res0)
  );

  fibm_reduce u_red1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start1),
    .value_i (val1),
    .mod_i   (red_mod),
    .done_o  (done1),
    .res_o   (res1)
  );

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mod_q <= mod_of(s_tdata_i[97:95]);
      x_q   <= '0;
      y_q   <= (s_tdata_i[97:95] == 3'd0) ? '0 : MOD_W'(1);
    end
    if (state_q == ST_SEED && done0) begin
      a_q <= res0;
      b_q <= res1;
    end
    if (state_q == ST_WAIT && done0) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (out_load) begin
      out_q <= res0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= CNT_W'(INDEX_BITS);
      end else if (state_q == ST_WAIT && done0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_q};

`ifndef SYNTHESIS
  a_red_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED || state_q == ST_WAIT) |-> (done0 == done1))
    else $error("reducers out of step");
  a_pair_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (x_q < mod_q && y_q < mod_q))
    else $error("pair not reduced");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_WAIT) |-> (cnt_q != '0))
    else $error("loop counter ran out");
`endif

endmodule

// ----- sim/tb_fibonacci_like_term_mod_pow10_core.sv -----
// Testbench for the Fibonacci-like term core: random and directed beats, scoreboard check.
module tb_fibonacci_like_term_mod_pow10_core
  import fibm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: predicts f(n) mod 10^m and holds pending terms
  class term_scoreboard;
    logic [13:0] pending_terms[$];
    int unsigned mismatches;

    function logic [13:0] predict_term(logic [31:0] sa, logic [31:0] sb,
                                       logic [30:0] n, logic [2:0] m);
      logic [63:0] md;
      logic [63:0] acc[4];
      logic [63:0] t[4];
      logic [63:0] av;
      logic [63:0] bv;
      case (m)
        3'd0: md = 64'd1;
        3'd1: md = 64'd10;
        3'd2: md = 64'd100;
        3'd3: md = 64'd1000;
        default: md = 64'd10000;
      endcase
      acc[0] = 64'd1 % md; acc[1] = 64'd0; acc[2] = 64'd0; acc[3] = 64'd1 % md;
      for (int i = INDEX_BITS - 1; i >= 0; i--) begin
        t[0] = (acc[0] * acc[0] + acc[1] * acc[2]) % md;
        t[1] = (acc[0] * acc[1] + acc[1] * acc[3]) % md;
        t[2] = (acc[2] * acc[0] + acc[3] * acc[2]) % md;
        t[3] = (acc[2] * acc[1] + acc[3] * acc[3]) % md;
        acc = t;
        if (n[i]) begin
          // multiply by [[1,1],[1,0]] reduced
          t[0] = (acc[0] + acc[1]) % md;
          t[1] = acc[0] % md;
          t[2] = (acc[2] + acc[3]) % md;
          t[3] = acc[2] % md;
          acc = t;
        end
      end
      av = {32'd0, sa} % md;
      bv = {32'd0, sb} % md;
      return 14'((acc[2] * bv + acc[3] * av) % md);
    endfunction

    function void note_input(logic [31:0] sa, logic [31:0] sb, logic [30:0] n,
                             logic [2:0] m);
      pending_terms = {pending_terms, predict_term(sa, sb, n, m)};
    endfunction

    function void check_term(logic [15:0] got);
      logic [13:0] want;
      if (pending_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: got %0d", got);
        return;
      end
      want = pending_terms.pop_front();
      if (got !== {2'b00, want}) begin
        mismatches++;
        if (mismatches <= 10) $display("term mismatch: expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_tvalid_i;
  logic s_tready_o;
  logic [103:0] s_tdata_i;
  logic m_tvalid_o;
  logic m_tready_i;
  logic [15:0] m_tdata_o;
  logic stim_done;

  term_scoreboard sb = new();

  fibonacci_like_term_mod_pow10_core DUT (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Send one beat, with a random gap before it; valid stays up when there is no gap
  task automatic send_beat(logic [31:0] sa, logic [31:0] sb2, logic [30:0] n, logic [2:0] m);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {6'd0, m, n, sb2, sa};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_input(sa, sb2, n, m);
  endtask

  task automatic random_beat();
    logic [30:0] n;
    case ($urandom_range(0, 3))
      0: n = 31'($urandom_range(0, 20));
      1: n = 31'($urandom_range(0, 1000));
      default: n = 31'($urandom);
    endcase
    send_beat($urandom, $urandom, n, 3'($urandom_range(0, 7)));
  endtask

  // Receiver: random wait before each beat, check each accepted beat
  initial begin
    int wait_cycles;
    m_tready_i = 1'b0;
    wait (rst_ni);
    forever begin
      wait_cycles = $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        m_tready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid_o) @(posedge clk_i);
      sb.check_term(m_tdata_o);
    end
  end

  initial begin
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: index extremes, every digit count, seed extremes
    for (int m = 0; m < 8; m++) send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE, 31'd0, 3'(m));
    send_beat(32'd7, 32'd9, 31'd1, 3'd4);
    send_beat(32'd0, 32'd0, 31'h7FFF_FFFF, 3'd4);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 3'd3);
    send_beat(32'd1, 32'd1, 31'd10, 3'd2);
    send_beat(32'd0, 32'd1, 31'h4000_0000, 3'd4);
    send_beat(32'h8000_0000, 32'h5555_5555, 31'h2AAA_AAAA, 3'd1);
    send_beat(32'h1234_5678, 32'hDEAD_BEEF, 31'h5555_5555, 3'd7);
    // Hold off until everything has drained
    s_tvalid_i <= 1'b0;
    while (sb.pending_terms.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 1000; i++) random_beat();
    s_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending_terms.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog: room for ~1020 items, several times over
  initial begin
    #(8ns * 4_000_000);
    $display("tb: failure");
    $finish;
  end
endmodule
